/* hw/rtl/ght_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ght_pkg
// Shared codes, field widths and record layout of the generational handle
// table.
// ----------------------------------------------------------------------------
package ght_pkg;

  localparam int unsigned ActionW   = 3;
  localparam int unsigned SlotW     = 6;
  localparam int unsigned GenW      = 16;
  localparam int unsigned DimW      = 16;
  localparam int unsigned UsageW    = 2;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned WidthOutW = 14;
  localparam int unsigned PitchW    = 16;
  localparam int unsigned LiveW     = 7;

  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 80;

  localparam logic [DimW-1:0] MaxWidth    = 16'd8192;
  localparam int unsigned     PitchShift  = 2;

  typedef enum logic [ActionW-1:0] {
    ACT_CREATE  = 3'd0,
    ACT_DESTROY = 3'd1,
    ACT_CHECK   = 3'd2,
    ACT_SIZE    = 3'd3,
    ACT_TARGET  = 3'd4
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_ARG   = 3'd1,
    ST_FULL      = 3'd2,
    ST_STALE     = 3'd3,
    ST_WRONG_USE = 3'd4
  } status_e;

  typedef enum logic [UsageW-1:0] {
    USE_STATIC    = 2'd0,
    USE_STREAMING = 2'd1,
    USE_TARGET    = 2'd2,
    USE_ANY       = 2'd3
  } usage_e;

  typedef enum logic [1:0] {
    FSM_CLEAR = 2'd0,
    FSM_IDLE  = 2'd1,
    FSM_EXEC  = 2'd2
  } fsm_e;

  typedef struct packed {
    logic [UsageW-1:0]    usage;
    logic [WidthOutW-1:0] width;
    logic [DimW-1:0]      height;
  } rec_t;

endpackage

/* hw/rtl/ght_free_finder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ght_free_finder
// Registered lowest-free-slot encoder. It tracks the next value of the alive
// vector so that its answer always matches the alive flops.
// ----------------------------------------------------------------------------
module ght_free_finder #(
  parameter int unsigned SLOTS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [SLOTS-1:0]           alive_d_i,
  output logic                       free_any_o,
  output logic [$clog2(SLOTS)-1:0]   free_idx_o
);

  localparam int unsigned SlotIdxW = $clog2(SLOTS);

  logic                free_any_d, free_any_q;
  logic [SlotIdxW-1:0] free_idx_d, free_idx_q;

  always_comb begin
    free_any_d = 1'b0;
    free_idx_d = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!alive_d_i[i]) begin
        free_any_d = 1'b1;
        free_idx_d = SlotIdxW'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_any_q <= 1'b1;
      free_idx_q <= '0;
    end else begin
      free_any_q <= free_any_d;
      free_idx_q <= free_idx_d;
    end
  end

  assign free_any_o = free_any_q;
  assign free_idx_o = free_idx_q;

endmodule

/* hw/rtl/generational_handle_table_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generational_handle_table_unit
// Slot table of texture records with per-slot generation counters.
// Flow: an item is taken in while the table is idle, which registers the record
// and generation memory reads; the execute state then checks it, writes back and
// loads the output register, waiting while that register holds an unaccepted result.
// The input stays closed until then, so items are taken one at a time.
// Reset: after reset the generation memory is cleared, one entry per cycle, over
// all SLOTS entries, during which no item is accepted.
// ----------------------------------------------------------------------------
module generational_handle_table_unit
  import ght_pkg::*;
#(
  parameter int unsigned SLOTS    = 64,
  parameter int unsigned GEN_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // handle_is_empty, handle_slot, handle_generation, new_width, new_height,
  // new_usage, required_usage, zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  // action
  input  logic [ActionW-1:0]  s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // status, slot_out, generation_out, width_out, height_out, row_pitch,
  // live_count, target_set, zero pad
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned SlotIdxW = $clog2(SLOTS);
  localparam int unsigned CntW     = $clog2(SLOTS + 1);
  localparam int unsigned GenCmpW  = (GEN_BITS > GenW) ? GEN_BITS : GenW;
  localparam int unsigned SlotExtW = (SlotIdxW > SlotW) ? SlotIdxW : SlotW;
  localparam int unsigned CntExtW  = (CntW > LiveW) ? CntW : LiveW;

  // Input unpacking.
  logic              in_empty;
  logic [SlotW-1:0]  in_slot;
  logic [GenW-1:0]   in_gen;
  logic [DimW-1:0]   in_w, in_h;
  logic [UsageW-1:0] in_usage, in_need;

  assign in_empty = s_axis_tdata[0];
  assign in_slot  = s_axis_tdata[6:1];
  assign in_gen   = s_axis_tdata[22:7];
  assign in_w     = s_axis_tdata[38:23];
  assign in_h     = s_axis_tdata[54:39];
  assign in_usage = s_axis_tdata[56:55];
  assign in_need  = s_axis_tdata[58:57];

  // Control state.
  fsm_e                state_q, state_d;
  logic [SlotIdxW-1:0] clr_cnt_q, clr_cnt_d;
  logic [SLOTS-1:0]    alive_q, alive_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                target_q, target_d;
  logic                out_valid_q, out_valid_d;

  // Captured item.
  action_e             act_q;
  logic                empty_q, in_range_q, free_any_cap_q;
  logic [GenW-1:0]     hgen_q;
  logic [DimW-1:0]     w_q, h_q;
  logic [UsageW-1:0]   usage_q, need_q;
  logic [SlotIdxW-1:0] idx_q;

  // Memories.
  logic [GEN_BITS-1:0] gen_mem [SLOTS];
  rec_t                rec_mem [SLOTS];
  logic [GEN_BITS-1:0] gen_rd_q;
  rec_t                rec_rd_q;

  logic                free_any;
  logic [SlotIdxW-1:0] free_idx;
  logic [SlotExtW-1:0] hslot_ext;
  logic [SlotIdxW-1:0] hslot_idx, rd_addr;
  logic                accept, commit;

  // Execute-stage outcome.
  logic                gen_we, rec_we;
  logic [GEN_BITS-1:0] gen_wdata;
  logic [SlotIdxW-1:0] wr_addr;
  rec_t                rec_wdata;
  status_e             status;
  logic [SlotW-1:0]    slot_o;
  logic [GenW-1:0]     gen_o;
  logic [WidthOutW-1:0] width_o;
  logic [DimW-1:0]     height_o;
  logic [PitchW-1:0]   pitch_o;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic                handle_ok, size_bad;
  logic [GEN_BITS-1:0] gen_first, gen_next;
  logic [GenCmpW-1:0]  gen_first_ext;
  logic [SlotExtW-1:0] idx_ext;
  logic [CntExtW-1:0]  cnt_ext;

  ght_free_finder #(
    .SLOTS(SLOTS)
  ) u_free (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .alive_d_i  (alive_d),
    .free_any_o (free_any),
    .free_idx_o (free_idx)
  );

  assign hslot_ext = SlotExtW'(in_slot);
  assign hslot_idx = hslot_ext[SlotIdxW-1:0];
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign commit    = (state_q == FSM_EXEC) && (!out_valid_q || m_axis_tready);
  assign rd_addr   = (action_e'(s_axis_tuser) == ACT_CREATE) ? free_idx : hslot_idx;

  // Next state.
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      FSM_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == SlotIdxW'(SLOTS - 1)) begin
          state_d = FSM_IDLE;
        end
      end
      FSM_IDLE: begin
        if (accept) begin
          state_d = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        if (commit) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_CLEAR;
    endcase
  end

  // Item evaluation on the registered memory reads.
  assign handle_ok = !empty_q && in_range_q && alive_q[idx_q] &&
                     (GenCmpW'(gen_rd_q) == GenCmpW'(hgen_q));
  assign size_bad  = (w_q == '0) || (h_q == '0) || (w_q > MaxWidth) ||
                     (usage_e'(usage_q) == USE_ANY);
  assign gen_first = (gen_rd_q == '0) ? GEN_BITS'(1) : gen_rd_q;
  assign gen_next  = ((gen_rd_q + 1'b1) == '0) ? GEN_BITS'(1) : gen_rd_q + 1'b1;
  assign gen_first_ext = GenCmpW'(gen_first);
  assign idx_ext   = SlotExtW'(idx_q);

  always_comb begin
    alive_d   = alive_q;
    count_d   = count_q;
    target_d  = target_q;
    gen_we    = 1'b0;
    rec_we    = 1'b0;
    gen_wdata = '0;
    wr_addr   = idx_q;
    rec_wdata.usage  = usage_q;
    rec_wdata.width  = w_q[WidthOutW-1:0];
    rec_wdata.height = h_q;
    status    = ST_OK;
    slot_o    = '0;
    gen_o     = '0;
    width_o   = '0;
    height_o  = '0;
    pitch_o   = '0;
    if (state_q == FSM_CLEAR) begin
      gen_we  = 1'b1;
      wr_addr = clr_cnt_q;
    end else if (commit) begin
      case (act_q)
        ACT_CREATE: begin
          if (size_bad) begin
            status = ST_BAD_ARG;
          end else if (!free_any_cap_q) begin
            status = ST_FULL;
          end else begin
            gen_we         = 1'b1;
            gen_wdata      = gen_first;
            rec_we         = 1'b1;
            alive_d[idx_q] = 1'b1;
            count_d        = count_q + 1'b1;
            slot_o         = idx_ext[SlotW-1:0];
            gen_o          = gen_first_ext[GenW-1:0];
            if (usage_e'(usage_q) == USE_STREAMING) begin
              pitch_o = PitchW'(w_q[WidthOutW-1:0]) << PitchShift;
            end
          end
        end
        ACT_DESTROY: begin
          if (!handle_ok) begin
            status = ST_STALE;
          end else begin
            gen_we         = 1'b1;
            gen_wdata      = gen_next;
            alive_d[idx_q] = 1'b0;
            count_d        = count_q - 1'b1;
          end
        end
        ACT_CHECK: begin
          if (!handle_ok) begin
            status = ST_STALE;
          end else if ((usage_e'(need_q) != USE_ANY) && (need_q != rec_rd_q.usage)) begin
            status = ST_WRONG_USE;
          end else if (usage_e'(rec_rd_q.usage) == USE_STREAMING) begin
            pitch_o = PitchW'(rec_rd_q.width) << PitchShift;
          end
        end
        ACT_SIZE: begin
          if (!handle_ok) begin
            status = ST_STALE;
          end else begin
            width_o  = rec_rd_q.width;
            height_o = rec_rd_q.height;
          end
        end
        ACT_TARGET: begin
          if (empty_q) begin
            target_d = 1'b0;
          end else if (!handle_ok) begin
            status = ST_STALE;
          end else if (usage_e'(rec_rd_q.usage) != USE_TARGET) begin
            status = ST_WRONG_USE;
          end else begin
            target_d = 1'b1;
          end
        end
        default: status = ST_BAD_ARG;
      endcase
    end
  end

  assign cnt_ext = CntExtW'(count_d);

  // Output register: a finished item waits here while the next is taken in.
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (commit) begin
      out_valid_d = 1'b1;
      out_data_d  = {1'b0, target_d, cnt_ext[LiveW-1:0], pitch_o, height_o, width_o,
                     gen_o, slot_o, status};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_CLEAR;
      clr_cnt_q   <= '0;
      alive_q     <= '0;
      count_q     <= '0;
      target_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      alive_q     <= alive_d;
      count_q     <= count_d;
      target_q    <= target_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (accept) begin
      act_q          <= action_e'(s_axis_tuser);
      empty_q        <= in_empty;
      in_range_q     <= 32'(in_slot) < 32'(SLOTS);
      free_any_cap_q <= free_any;
      hgen_q         <= in_gen;
      w_q            <= in_w;
      h_q            <= in_h;
      usage_q        <= in_usage;
      need_q         <= in_need;
      idx_q          <= rd_addr;
    end
  end

  // Generation memory.
  always_ff @(posedge clk_i) begin
    if (gen_we) begin
      gen_mem[wr_addr] <= gen_wdata;
    end
    if (accept) begin
      gen_rd_q <= gen_mem[rd_addr];
    end
  end

  // Record memory.
  always_ff @(posedge clk_i) begin
    if (rec_we) begin
      rec_mem[wr_addr] <= rec_wdata;
    end
    if (accept) begin
      rec_rd_q <= rec_mem[rd_addr];
    end
  end

  assign s_axis_tready = (state_q == FSM_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

/* hw/rtl/ght_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ght_checker
// Port-level checks of the generational handle table, bound to the top level.
// ----------------------------------------------------------------------------
module ght_checker
  import ght_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  // A stalled result item holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  // Items are taken one at a time, so the input closes right after an accept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted two cycles in a row");

  // A failed item carries no handle, size or pitch.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[2:0] != ST_OK) |->
      (m_axis_tdata[70:3] == '0))
    else $error("failed item carries payload");

  // Stored widths never pass the creation limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[38:25] <= 14'd8192))
    else $error("width above limit");

  // Only a size query reports a size, and it carries no handle or pitch.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[38:25] != '0) |->
      (m_axis_tdata[24:3] == '0) && (m_axis_tdata[70:55] == '0))
    else $error("size reported with other fields");

endmodule

bind generational_handle_table_unit ght_checker u_ght_checker (.*);

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the generational handle table. A driver feeds
// table operations from a backlog, a software copy of the slot map computes
// the reply of every accepted item, and a monitor checks each reply field by
// field. The run covers directed corner cases, a random phase that fills
// the table and drains it again, and a short churn that recycles one slot
// so that its generation advances.
// ----------------------------------------------------------------------------
module tb;
  import ght_pkg::*;

  localparam int unsigned NumSlots    = 64;
  localparam int unsigned RandomOps   = 1850;
  localparam int unsigned ChurnRounds = 4;
  localparam int unsigned CycleLimit  = 4000000;
  localparam int unsigned StallCycles = 400;
  localparam int unsigned MaxShown    = 10;
  localparam int unsigned IdlePct     = 31;
  localparam int unsigned DrainCycles = 8;

  localparam logic [GenW-1:0]    FirstGen  = 16'd1;
  localparam logic [GenW-1:0]    LastGen   = 16'hFFFF;
  localparam logic [ActionW-1:0] ActSpare0 = 3'd5;
  localparam logic [ActionW-1:0] ActSpare2 = 3'd7;

  // Input fields in tdata order from the top; the last field sits in the lowest bits.
  typedef struct packed {
    usage_e           required_usage;
    usage_e           new_usage;
    logic [DimW-1:0]  new_height;
    logic [DimW-1:0]  new_width;
    logic [GenW-1:0]  handle_generation;
    logic [SlotW-1:0] handle_slot;
    logic             handle_is_empty;
  } op_args_t;

  typedef struct packed {
    logic [ActionW-1:0] action;
    op_args_t           args;
  } table_op_t;

  typedef struct packed {
    logic                 target_set;
    logic [LiveW-1:0]     live_count;
    logic [PitchW-1:0]    row_pitch;
    logic [DimW-1:0]      height_out;
    logic [WidthOutW-1:0] width_out;
    logic [GenW-1:0]      generation_out;
    logic [SlotW-1:0]     slot_out;
    logic [StatusW-1:0]   status;
  } table_reply_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [ActionW-1:0]  s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  generational_handle_table_unit #(
    .SLOTS    (NumSlots),
    .GEN_BITS (GenW)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Shadow copy of the slot map, updated as items are accepted.
  logic                 map_alive  [NumSlots];
  logic [GenW-1:0]      map_gen    [NumSlots];
  usage_e               map_usage  [NumSlots];
  logic [WidthOutW-1:0] map_width  [NumSlots];
  logic [DimW-1:0]      map_height [NumSlots];
  logic [LiveW-1:0]     map_live;
  logic                 map_target;

  table_op_t    op_backlog[$];
  table_reply_t pending_replies[$];
  table_op_t    op_on_bus;

  int unsigned pushed_cnt  = 0;
  int unsigned taken_cnt   = 0;
  int unsigned checked_cnt = 0;
  int unsigned err_cnt     = 0;
  int unsigned wrap_cnt    = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned status_seen [8];
  int unsigned hold_left   = 0;
  bit          calm        = 1'b0;
  bit          stall_req   = 1'b0;
  bit          stall_done  = 1'b0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Timed out after %0d cycles with %0d replies outstanding.", cycle_cnt,
             pending_replies.size());
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [PitchW-1:0] pitch_of(int s);
    return (map_usage[s] == USE_STREAMING) ? (PitchW'(map_width[s]) << PitchShift) : '0;
  endfunction

  // Applies one operation to the shadow map and returns the reply it earns.
  function automatic table_reply_t slot_map_reply(table_op_t op);
    table_reply_t r;
    int           s;
    logic         live;
    r = '0;
    r.status = ST_OK;
    s = op.args.handle_slot;
    live = !op.args.handle_is_empty && map_alive[s] &&
           map_gen[s] == op.args.handle_generation;
    case (op.action)
      ACT_CREATE: begin
        if (op.args.new_width == '0 || op.args.new_height == '0 ||
            op.args.new_width > MaxWidth || op.args.new_usage == USE_ANY) begin
          r.status = ST_BAD_ARG;
        end else begin
          s = -1;
          for (int i = NumSlots - 1; i >= 0; i--) begin
            if (!map_alive[i]) s = i;
          end
          if (s < 0) begin
            r.status = ST_FULL;
          end else begin
            if (map_gen[s] == '0) map_gen[s] = FirstGen;
            map_alive[s]  = 1'b1;
            map_usage[s]  = op.args.new_usage;
            map_width[s]  = op.args.new_width[WidthOutW-1:0];
            map_height[s] = op.args.new_height;
            map_live++;
            r.slot_out       = SlotW'(s);
            r.generation_out = map_gen[s];
            r.row_pitch      = pitch_of(s);
          end
        end
      end
      ACT_DESTROY: begin
        if (!live) begin
          r.status = ST_STALE;
        end else begin
          map_alive[s] = 1'b0;
          if (map_gen[s] == LastGen) begin
            map_gen[s] = FirstGen;
            wrap_cnt++;
          end else begin
            map_gen[s]++;
          end
          map_live--;
        end
      end
      ACT_CHECK: begin
        if (!live) r.status = ST_STALE;
        else if (op.args.required_usage != USE_ANY &&
                 op.args.required_usage != map_usage[s]) r.status = ST_WRONG_USE;
        else r.row_pitch = pitch_of(s);
      end
      ACT_SIZE: begin
        if (!live) begin
          r.status = ST_STALE;
        end else begin
          r.width_out  = map_width[s];
          r.height_out = map_height[s];
        end
      end
      ACT_TARGET: begin
        if (op.args.handle_is_empty) map_target = 1'b0;
        else if (!live) r.status = ST_STALE;
        else if (map_usage[s] != USE_TARGET) r.status = ST_WRONG_USE;
        else map_target = 1'b1;
      end
      default: r.status = ST_BAD_ARG;
    endcase
    r.live_count = map_live;
    r.target_set = map_target;
    return r;
  endfunction

  // Driver: a valid item stays on the bus until the block takes it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      map_live   = '0;
      map_target = 1'b0;
      for (int i = 0; i < NumSlots; i++) begin
        map_alive[i] = 1'b0;
        map_gen[i]   = '0;
      end
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        pending_replies.push_back(slot_map_reply(op_on_bus));
        status_seen[pending_replies[$].status]++;
        taken_cnt++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (op_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= IdlePct)) begin
          op_on_bus = op_backlog.pop_front();
          s_axis_tuser  <= op_on_bus.action;
          s_axis_tdata  <= InDataW'(op_on_bus.args);
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic flag_error(string msg);
    err_cnt++;
    if (err_cnt <= MaxShown) $display("Mismatch: %s", msg);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      flag_error($sformatf("reply %0d %s expected %0d, got %0d", checked_cnt, name, want, got));
    end
  endtask

  task automatic check_reply(table_reply_t got);
    table_reply_t want;
    if (pending_replies.size() == 0) begin
      flag_error($sformatf("reply with no operation outstanding: %h", got));
      return;
    end
    want = pending_replies.pop_front();
    check_field("status", want.status, got.status);
    check_field("slot_out", want.slot_out, got.slot_out);
    check_field("generation_out", want.generation_out, got.generation_out);
    check_field("width_out", want.width_out, got.width_out);
    check_field("height_out", want.height_out, got.height_out);
    check_field("row_pitch", want.row_pitch, got.row_pitch);
    check_field("live_count", want.live_count, got.live_count);
    check_field("target_set", want.target_set, got.target_set);
    checked_cnt++;
  endtask

  // Monitor: random back-pressure plus one long hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_reply(m_axis_tdata[$bits(table_reply_t)-1:0]);
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_req && !stall_done) begin
        stall_done = 1'b1;
        hold_left  = StallCycles;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || $urandom_range(0, 99) >= IdlePct;
      end
    end
  end

  task automatic send_op(table_op_t op, int unsigned depth);
    while (pushed_cnt - taken_cnt >= depth) @(negedge clk_i);
    op_backlog.push_back(op);
    pushed_cnt++;
  endtask

  task automatic settle();
    while (pushed_cnt != taken_cnt) @(negedge clk_i);
  endtask

  function automatic table_op_t op_of(logic [ActionW-1:0] act, logic empty,
                                      logic [SlotW-1:0] slot, logic [GenW-1:0] gen,
                                      logic [DimW-1:0] w, logic [DimW-1:0] h,
                                      usage_e use_new, usage_e use_need);
    table_op_t op;
    op.action                 = act;
    op.args.handle_is_empty   = empty;
    op.args.handle_slot       = slot;
    op.args.handle_generation = gen;
    op.args.new_width         = w;
    op.args.new_height        = h;
    op.args.new_usage         = use_new;
    op.args.required_usage    = use_need;
    return op;
  endfunction

  // Mostly well-formed traffic: handles are usually taken from live slots of
  // the shadow map, the rest are stale, random or null.
  function automatic table_op_t random_op(bit grow);
    table_op_t   op;
    logic [63:0] raw;
    int unsigned pick;
    int unsigned kind;
    int          s0;
    int          s;
    raw = {$urandom, $urandom};
    op.args = raw[$bits(op_args_t)-1:0];
    op.args.handle_is_empty = ($urandom_range(0, 19) == 0);
    pick = $urandom_range(0, 99);
    if (pick < (grow ? 40 : 18)) op.action = ACT_CREATE;
    else if (pick < (grow ? 55 : 50)) op.action = ACT_DESTROY;
    else if (pick < (grow ? 70 : 65)) op.action = ACT_CHECK;
    else if (pick < (grow ? 83 : 78)) op.action = ACT_SIZE;
    else if (pick < 96) op.action = ACT_TARGET;
    else op.action = ActionW'($urandom_range(ActSpare0, ActSpare2));

    if (op.action == ACT_CREATE) begin
      case ($urandom_range(0, 9))
        0: op.args.new_width = ($urandom_range(0, 1) == 0) ? 16'd0 :
                               DimW'($urandom_range(8193, 65535));
        1: op.args.new_width = ($urandom_range(0, 1) == 0) ? 16'd1 : MaxWidth;
        default: op.args.new_width = DimW'($urandom_range(1, 8192));
      endcase
      op.args.new_height = ($urandom_range(0, 11) == 0) ? 16'd0 :
                           DimW'($urandom_range(1, 65535));
      op.args.new_usage  = ($urandom_range(0, 11) == 0) ? USE_ANY :
                           usage_e'($urandom_range(0, 2));
    end else begin
      kind = $urandom_range(0, 9);
      s0 = $urandom_range(0, NumSlots - 1);
      s = -1;
      for (int j = 0; j < NumSlots; j++) begin
        if (s < 0 && map_alive[(s0 + j) % NumSlots]) s = (s0 + j) % NumSlots;
      end
      if (kind < 8 && s >= 0) begin
        op.args.handle_slot       = SlotW'(s);
        op.args.handle_generation = map_gen[s];
        // An old generation of a live slot must be refused.
        if (kind == 7) op.args.handle_generation = map_gen[s] - 16'd1;
      end
    end
    return op;
  endfunction

  initial begin
    int f;
    // Directed corner cases, starting from an empty table.
    send_op(op_of(ACT_SIZE, 1'b0, 6'd0, 16'd0, 16'd1, 16'd1, USE_STATIC, USE_ANY), 4);
    send_op(op_of(ACT_SIZE, 1'b0, 6'd63, LastGen, 16'd1, 16'd1, USE_STATIC, USE_ANY), 4);
    send_op(op_of(ACT_CREATE, 1'b0, 6'd0, 16'd0, 16'd0, 16'd10, USE_STATIC, USE_ANY), 4);
    send_op(op_of(ACT_CREATE, 1'b0, 6'd0, 16'd0, 16'd8193, 16'd10, USE_STATIC, USE_ANY), 4);
    send_op(op_of(ACT_CREATE, 1'b0, 6'd0, 16'd0, 16'd10, 16'd0, USE_STATIC, USE_ANY), 4);
    send_op(op_of(ACT_CREATE, 1'b0, 6'd0, 16'd0, 16'd10, 16'd10, USE_ANY, USE_ANY), 4);
    send_op(op_of(ACT_CREATE, 1'b0, 6'd0, 16'd0, MaxWidth, 16'hFFFF, USE_STREAMING,
                  USE_ANY), 4);
    send_op(op_of(ACT_CREATE, 1'b0, 6'd0, 16'd0, 16'd1, 16'd1, USE_TARGET, USE_ANY), 4);
    send_op(op_of(ACT_CREATE, 1'b0, 6'd0, 16'd0, 16'd100, 16'd50, USE_STATIC, USE_ANY), 4);
    send_op(op_of(ACT_CHECK, 1'b0, 6'd0, 16'd1, 16'd0, 16'd0, USE_STATIC, USE_STREAMING), 4);
    send_op(op_of(ACT_CHECK, 1'b0, 6'd2, 16'd1, 16'd0, 16'd0, USE_STATIC, USE_TARGET), 4);
    send_op(op_of(ACT_CHECK, 1'b0, 6'd1, 16'd1, 16'd0, 16'd0, USE_STATIC, USE_ANY), 4);
    send_op(op_of(ACT_SIZE, 1'b0, 6'd0, 16'd1, 16'd0, 16'd0, USE_STATIC, USE_ANY), 4);
    send_op(op_of(ACT_SIZE, 1'b0, 6'd0, 16'd2, 16'd0, 16'd0, USE_STATIC, USE_ANY), 4);
    send_op(op_of(ACT_TARGET, 1'b0, 6'd2, 16'd1, 16'd0, 16'd0, USE_STATIC, USE_ANY), 4);
    send_op(op_of(ACT_TARGET, 1'b0, 6'd1, 16'd1, 16'd0, 16'd0, USE_STATIC, USE_ANY), 4);
    send_op(op_of(ACT_TARGET, 1'b1, 6'd1, 16'd1, 16'd0, 16'd0, USE_STATIC, USE_ANY), 4);
    send_op(op_of(ACT_TARGET, 1'b0, 6'd1, 16'd1, 16'd0, 16'd0, USE_STATIC, USE_ANY), 4);
    // The held target survives destruction of its texture.
    send_op(op_of(ACT_DESTROY, 1'b0, 6'd1, 16'd1, 16'd0, 16'd0, USE_STATIC, USE_ANY), 4);
    send_op(op_of(ACT_DESTROY, 1'b0, 6'd1, 16'd1, 16'd0, 16'd0, USE_STATIC, USE_ANY), 4);
    send_op(op_of(ACT_DESTROY, 1'b1, 6'd0, 16'd1, 16'd0, 16'd0, USE_STATIC, USE_ANY), 4);
    send_op(op_of(ACT_CHECK, 1'b1, 6'd0, 16'd1, 16'd0, 16'd0, USE_STATIC, USE_ANY), 4);
    send_op(op_of(ACT_TARGET, 1'b0, 6'd1, 16'd1, 16'd0, 16'd0, USE_STATIC, USE_ANY), 4);
    send_op(op_of(ACT_CREATE, 1'b0, 6'd0, 16'd0, 16'd4096, 16'd7, USE_TARGET, USE_ANY), 4);
    send_op(op_of(ActSpare0, 1'b0, 6'd0, 16'd1, 16'd1, 16'd1, USE_STATIC, USE_ANY), 4);
    send_op(op_of(ActSpare2, 1'b0, 6'd0, 16'd1, 16'd1, 16'd1, USE_STATIC, USE_ANY), 4);

    // Random traffic: the first half fills the table, the second drains it.
    for (int n = 0; n < RandomOps; n++) begin
      if (n == 700) stall_req = 1'b1;
      calm = (n >= 1100 && n < 1400);
      send_op(random_op(n < RandomOps / 2), 2);
    end

    // Empty the table, then recycle slot zero a few times so that its
    // generation advances.
    settle();
    for (int j = 0; j < NumSlots; j++) begin
      if (map_alive[j]) begin
        send_op(op_of(ACT_DESTROY, 1'b0, SlotW'(j), map_gen[j], 16'd0, 16'd0, USE_STATIC,
                      USE_ANY), 4);
      end
    end
    for (int k = 0; k < ChurnRounds; k++) begin
      send_op(op_of(ACT_CREATE, 1'b0, 6'd0, 16'd0, 16'd16, 16'd16, USE_STREAMING,
                    USE_ANY), 4);
      settle();
      f = 0;
      send_op(op_of(ACT_DESTROY, 1'b0, SlotW'(f), map_gen[f], 16'd0, 16'd0, USE_STATIC,
                    USE_ANY), 4);
    end

    settle();
    while (pending_replies.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("Ran %0d operations, %0d replies checked: %0d ok, %0d bad argument, %0d full,",
             taken_cnt, checked_cnt, status_seen[ST_OK], status_seen[ST_BAD_ARG],
             status_seen[ST_FULL]);
    $display("%0d stale, %0d wrong usage; %0d generation wraps; %0d mismatches.",
             status_seen[ST_STALE], status_seen[ST_WRONG_USE], wrap_cnt, err_cnt);
    if (err_cnt == 0 && pending_replies.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* generational_handle_table_unit.f */
hw/rtl/ght_pkg.sv
hw/rtl/ght_free_finder.sv
hw/rtl/generational_handle_table_unit.sv
hw/rtl/ght_checker.sv
dv/tb.sv
